@@ src/sita_pkg.sv @@
// Shared types, constants and character helpers for the integer-to-ASCII unit.
`timescale 1ns / 1ps

package sita_pkg;

    localparam int C_VALUE_W   = 64;
    localparam int C_DIGIT_W   = 4;
    localparam int C_DEC_DIGITS = 20;
    localparam int C_HEX_DIGITS = 16;
    localparam int C_DIGITS_W  = C_DEC_DIGITS * C_DIGIT_W;
    localparam int C_REM_W     = $clog2(C_DEC_DIGITS + 1);
    localparam int C_BIT_CNT_W = $clog2(C_VALUE_W);

    localparam logic [7:0] C_CHAR_ZERO    = 8'd48;
    localparam logic [7:0] C_CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] C_CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] C_CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] C_CHAR_NONE    = 8'h00;

    typedef enum logic [1:0] {
        CMD_DEC       = 2'd0,
        CMD_HEX_UPPER = 2'd1,
        CMD_HEX_LOWER = 2'd2,
        CMD_REJECT    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT,
        ST_REJECT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic skip;
        logic emit_sign;
        logic emit_digit;
        logic emit_reject;
    } t_dp_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic top_zero;
        logic last_digit;
        logic neg;
    } t_dp_status;

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? C_CHAR_UPPER_A : C_CHAR_LOWER_A;
        if (d < 4'd10) begin
            hex_char = C_CHAR_ZERO + {4'd0, d};
        end else begin
            hex_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

    function automatic logic [7:0] dec_char(input logic [3:0] d);
        dec_char = C_CHAR_ZERO + {4'd0, d};
    endfunction

endpackage

@@ src/signed_int_to_ascii_radix_unit.sv @@
// Top level of the signed 64-bit integer to ASCII text converter.
//
// Usage: present i_value and i_command and raise start; the word is taken at a
// rising edge with start high and busy low. Commands: decimal, upper-case hex,
// lower-case hex, or reject. Text comes out most significant character first,
// one character per o_valid strobe, with o_last on the final character.
// Decimal output leads with '-' for negative values; hex prints the magnitude.
// A rejected command gives a single strobe with o_rejected and o_last set.
// Results are held for exactly one cycle; the receiver cannot stall them.
//
// Sequence: decimal runs a shift-and-add-3 binary-to-BCD pass over all 64 input
// bits, then steps through all 20 BCD digits, skipping a leading zero or
// emitting a character at each, plus a step for '-' when the value is
// negative. Hex steps through all 16 digits. Reject passes through a single
// reject state. The next word is taken only while busy is low, so one item
// is in flight at a time.
// Each character appears in the cycle after the state that emits it.
// Synchronous reset returns the controller to idle and drops any strobe.
`timescale 1ns / 1ps

module signed_int_to_ascii_radix_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] i_value,
    input  logic [1:0]         i_command,
    output logic               o_valid,
    output logic [7:0]         o_text_char,
    output logic               o_last,
    output logic               o_rejected
);
    import sita_pkg::*;

    t_dp_ctrl   ctrl;
    t_dp_status status;

    sita_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_status  (status),
        .o_ctrl    (ctrl),
        .busy      (busy)
    );

    sita_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_value     (i_value),
        .i_command   (i_command),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last      (o_last),
        .o_rejected  (o_rejected)
    );

    // an accepted word always keeps the unit busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting a word");

    // a reject word is always a lone final word
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_last && (o_text_char == C_CHAR_NONE)))
        else $error("rejected word is not a final NUL word");

    // once idle, any word still on the outputs is the end of its conversion
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && o_valid) |-> o_last)
        else $error("unit went idle before the final character");

endmodule

@@ src/sita_datapath.sv @@
// Datapath: magnitude, BCD/hex digit register, digit counter and output word register.
`timescale 1ns / 1ps

module sita_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sita_pkg::t_dp_ctrl          i_ctrl,
    input  logic signed [63:0]          i_value,
    input  logic [1:0]                  i_command,
    output sita_pkg::t_dp_status        o_status,
    output logic                        o_valid,
    output logic [7:0]                  o_text_char,
    output logic                        o_last,
    output logic                        o_rejected
);
    import sita_pkg::*;

    logic [C_VALUE_W-1:0]  r_bin, n_bin;
    logic [C_DIGITS_W-1:0] r_digits, n_digits;
    logic [C_REM_W-1:0]    r_remaining, n_remaining;
    logic                  r_neg, n_neg;
    t_cmd                  r_mode, n_mode;
    logic                  r_valid, n_valid;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;
    logic                  r_rej, n_rej;

    logic [C_VALUE_W-1:0]  mag;
    logic [C_DIGITS_W-1:0] adjusted;
    logic [C_DIGIT_W-1:0]  top_digit;
    logic                  last_digit;

    assign mag        = i_value[C_VALUE_W-1] ? (~i_value + 64'd1) : i_value;
    assign top_digit  = r_digits[C_DIGITS_W-1 -: C_DIGIT_W];
    assign last_digit = (r_remaining == C_REM_W'(1));

    // Double-dabble correction: each BCD digit of 5 or more gets 3 added before the shift
    always_comb begin
        for (int i = 0; i < C_DEC_DIGITS; i++) begin
            if (r_digits[i*C_DIGIT_W +: C_DIGIT_W] >= 4'd5) begin
                adjusted[i*C_DIGIT_W +: C_DIGIT_W] = r_digits[i*C_DIGIT_W +: C_DIGIT_W] + 4'd3;
            end else begin
                adjusted[i*C_DIGIT_W +: C_DIGIT_W] = r_digits[i*C_DIGIT_W +: C_DIGIT_W];
            end
        end
    end

    always_comb begin
        n_bin       = r_bin;
        n_digits    = r_digits;
        n_remaining = r_remaining;
        n_neg       = r_neg;
        n_mode      = r_mode;
        n_valid     = 1'b0;
        n_char      = r_char;
        n_last      = r_last;
        n_rej       = r_rej;

        if (i_ctrl.load) begin
            n_mode = t_cmd'(i_command);
            n_neg  = i_value[C_VALUE_W-1];
            n_bin  = mag;
            if (t_cmd'(i_command) == CMD_DEC) begin
                n_digits    = '0;
                n_remaining = C_REM_W'(C_DEC_DIGITS);
            end else begin
                n_digits    = {mag, {(C_DIGITS_W-C_VALUE_W){1'b0}}};
                n_remaining = C_REM_W'(C_HEX_DIGITS);
            end
        end

        if (i_ctrl.dabble) begin
            n_digits = {adjusted[C_DIGITS_W-2:0], r_bin[C_VALUE_W-1]};
            n_bin    = {r_bin[C_VALUE_W-2:0], 1'b0};
        end

        if (i_ctrl.skip || i_ctrl.emit_digit) begin
            n_digits    = {r_digits[C_DIGITS_W-C_DIGIT_W-1:0], {C_DIGIT_W{1'b0}}};
            n_remaining = r_remaining - C_REM_W'(1);
        end

        if (i_ctrl.emit_digit) begin
            n_valid = 1'b1;
            n_last  = last_digit;
            n_rej   = 1'b0;
            unique case (r_mode)
                CMD_DEC:       n_char = dec_char(top_digit);
                CMD_HEX_UPPER: n_char = hex_char(top_digit, 1'b1);
                CMD_HEX_LOWER: n_char = hex_char(top_digit, 1'b0);
                default:       n_char = C_CHAR_NONE;
            endcase
        end

        if (i_ctrl.emit_sign) begin
            n_valid = 1'b1;
            n_char  = C_CHAR_MINUS;
            n_last  = 1'b0;
            n_rej   = 1'b0;
        end

        if (i_ctrl.emit_reject) begin
            n_valid = 1'b1;
            n_char  = C_CHAR_NONE;
            n_last  = 1'b1;
            n_rej   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_bin       <= n_bin;
        r_digits    <= n_digits;
        r_remaining <= n_remaining;
        r_neg       <= n_neg;
        r_mode      <= n_mode;
        r_char      <= n_char;
        r_last      <= n_last;
        r_rej       <= n_rej;
    end

    assign o_status.top_zero   = (top_digit == '0);
    assign o_status.last_digit = last_digit;
    assign o_status.neg        = r_neg;

    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last      = r_last;
    assign o_rejected  = r_rej;

endmodule

@@ src/sita_ctrl.sv @@
// Controller: sequences load, binary-to-BCD conversion, leading-zero skip and emission.
`timescale 1ns / 1ps

module sita_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_command,
    input  sita_pkg::t_dp_status  i_status,
    output sita_pkg::t_dp_ctrl    o_ctrl,
    output logic                  busy
);
    import sita_pkg::*;

    t_state                 r_state, n_state;
    logic [C_BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        o_ctrl    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_bit_cnt   = '0;
                    unique case (t_cmd'(i_command))
                        CMD_DEC:    n_state = ST_CONVERT;
                        CMD_REJECT: n_state = ST_REJECT;
                        default:    n_state = ST_SKIP;
                    endcase
                end
            end
            ST_CONVERT: begin
                o_ctrl.dabble = 1'b1;
                n_bit_cnt     = r_bit_cnt + C_BIT_CNT_W'(1);
                if (r_bit_cnt == {C_BIT_CNT_W{1'b1}}) begin
                    n_state = i_status.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                o_ctrl.emit_sign = 1'b1;
                n_state          = ST_SKIP;
            end
            ST_SKIP: begin
                // drop leading zeros, but always keep the final digit
                if (i_status.top_zero && !i_status.last_digit) begin
                    o_ctrl.skip = 1'b1;
                end else begin
                    o_ctrl.emit_digit = 1'b1;
                    n_state = i_status.last_digit ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_ctrl.emit_digit = 1'b1;
                if (i_status.last_digit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REJECT: begin
                o_ctrl.emit_reject = 1'b1;
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule
